// ----- hdl/hdcc_pkg.sv -----
// Shared constants, stage types and lookup functions for the HVAC duty-cycle time calculator.
// Depends on nothing; used by hvac_duty_cycle_time_calc.
package hdcc_pkg;

  // Fixed-point formats
  localparam int unsigned DataW     = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned FracW     = FracBits + 1;      // 0..65536, 65536 is 1.0
  localparam int unsigned KW        = 9;                 // half-cycle constant, up to 450
  localparam int unsigned QuotW     = KW + FracBits;     // quotient of K*65536 / divisor
  localparam int unsigned LimitW    = 10;
  localparam int unsigned SelW      = 3;
  localparam int unsigned NumCph    = 5;
  localparam int unsigned FracSteps = FracBits;          // one quotient bit per stage
  localparam int unsigned DivSteps  = QuotW;

  localparam logic [FracW-1:0] FracOne = FracW'(1) << FracBits;

  // Configuration port
  localparam int unsigned AddrW = 5;
  localparam logic [2:0] RegPvLower  = 3'd0;
  localparam logic [2:0] RegPvUpper  = 3'd1;
  localparam logic [2:0] RegCphSel   = 3'd2;
  localparam logic [2:0] RegMinOn    = 3'd3;
  localparam logic [2:0] RegMinOff   = 3'd4;

  localparam logic OpOffTime = 1'b0;
  localparam logic OpOnTime  = 1'b1;

  // Input word held in the skid stage
  typedef struct packed {
    logic              op;
    logic [DataW-1:0]  sample;
  } in_word_t;

  // Load-fraction divider stage
  typedef struct packed {
    logic                op;
    logic                force_zero;
    logic                force_one;
    logic [DataW-1:0]    rem;
    logic [DataW-1:0]    range;
    logic [FracBits-1:0] quot;
  } frac_stage_t;

  // Cycle-time divider stage
  typedef struct packed {
    logic             op;
    logic             dzero;
    logic [FracW-1:0] dvsr;
    logic [FracW-1:0] rem;
    logic [QuotW-1:0] quot;
  } div_stage_t;

  // Half of one cycle in seconds for each cycles-per-hour option
  function automatic logic [KW-1:0] half_cycle_secs(input logic [SelW-1:0] sel);
    logic [KW-1:0] k;
    case (sel)
      3'd0:    k = KW'(450);
      3'd1:    k = KW'(300);
      3'd2:    k = KW'(225);
      3'd3:    k = KW'(180);
      3'd4:    k = KW'(150);
      default: k = '0;
    endcase
    return k;
  endfunction

  // Largest allowed minimum time for each cycles-per-hour option
  function automatic logic [LimitW-1:0] max_min_limit(input logic [SelW-1:0] sel);
    logic [LimitW-1:0] l;
    case (sel)
      3'd0:    l = LimitW'(900);
      3'd1:    l = LimitW'(600);
      3'd2:    l = LimitW'(450);
      3'd3:    l = LimitW'(360);
      3'd4:    l = LimitW'(300);
      default: l = '0;
    endcase
    return l;
  endfunction

endpackage

// ----- hdl/hvac_duty_cycle_time_calc.sv -----
// HVAC duty-cycle time calculator: pipelined load-fraction and cycle-time dividers.
// Depends on hdcc_pkg for formats, stage types and the per-option lookup tables.
//
// Usage: each input word carries a signed Q16.16 process-variable sample in
// s_axis_tdata and the selector in s_axis_tuser (0 off time, 1 on time). Each
// output word carries the cycle time in seconds and the per-option minimum-time
// limit in m_axis_tdata, and the invalid-option flag in m_axis_tuser.
// The sample is normalized against the configured bounds by a 16-stage
// restoring divider (one fraction bit per stage), then the half-cycle constant
// is divided by the fraction or by one minus it in a 25-stage restoring divider.
// A final stage applies the capped minimum time.
// The pipeline takes one word per cycle while the receiver does not stall. When the
// receiver stalls, the whole pipeline holds; a skid register at the input catches
// the word taken in the stall cycle, so s_axis_tready falls in the cycle after it
// and nothing is lost or repeated. Reset clears all valid bits and loads the
// register defaults (lower bound 0, upper bound 1.0, option 0, minimum times 0).
// The user must write registers over the APB port only while no word is in flight;
// the block does not enforce this. The entry stage, the cycle-time divider and the
// output stage read them live.
module hvac_duty_cycle_time_calc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,   // [31:0] pv_sample
  input  logic [0:0]                 s_axis_tuser,   // [0] op
  // Output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [47:0]                m_axis_tdata,   // [31:0] cycle_seconds,
                                                     // [41:32] min_time_limit, rest zero
  output logic [0:0]                 m_axis_tuser,   // [0] cph_invalid
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hdcc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned NF = hdcc_pkg::FracSteps;
  localparam int unsigned ND = hdcc_pkg::DivSteps;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0]                 pv_lower_q, pv_upper_q, min_on_q, min_off_q;
  logic [hdcc_pkg::SelW-1:0]   cph_sel_q;
  logic                        cfg_wr;
  logic [2:0]                  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_lower_q <= '0;
      pv_upper_q <= 32'h0001_0000;
      cph_sel_q  <= '0;
      min_on_q   <= '0;
      min_off_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        hdcc_pkg::RegPvLower: pv_lower_q <= pwdata;
        hdcc_pkg::RegPvUpper: pv_upper_q <= pwdata;
        hdcc_pkg::RegCphSel:  cph_sel_q  <= pwdata[hdcc_pkg::SelW-1:0];
        hdcc_pkg::RegMinOn:   min_on_q   <= pwdata;
        hdcc_pkg::RegMinOff:  min_off_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hdcc_pkg::RegPvLower: prdata = pv_lower_q;
      hdcc_pkg::RegPvUpper: prdata = pv_upper_q;
      hdcc_pkg::RegCphSel:  prdata = 32'(cph_sel_q);
      hdcc_pkg::RegMinOn:   prdata = min_on_q;
      hdcc_pkg::RegMinOff:  prdata = min_off_q;
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the output word is
  // held by the receiver. The skid register keeps s_axis_tready registered.
  // ---------------------------------------------------------------------------
  logic                 pipe_en;
  logic                 s_accept;
  logic                 skid_valid_q, skid_valid_d;
  hdcc_pkg::in_word_t   skid_q, in_word, src_word;
  logic                 src_valid;
  logic                 out_valid_q;

  assign pipe_en       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !skid_valid_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_word.op     = s_axis_tuser[0];
  assign in_word.sample = s_axis_tdata;

  assign src_valid = skid_valid_q || s_accept;
  assign src_word  = skid_valid_q ? skid_q : in_word;

  always_comb begin
    skid_valid_d = skid_valid_q;
    if (pipe_en) begin
      skid_valid_d = 1'b0;
    end else if (s_accept) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!pipe_en && s_accept) begin
      skid_q <= in_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Load fraction. The entry stage sorts out the clamped cases with plain
  // signed compares: below the lower bound gives 0, and at or above the upper
  // bound (or a non-positive range) gives 1.0. Otherwise 0 <= diff < range,
  // and 16 restoring steps produce the Q0.16 fraction.
  // ---------------------------------------------------------------------------
  hdcc_pkg::frac_stage_t fp_q [NF+1];
  hdcc_pkg::frac_stage_t fp_d [NF+1];
  logic [NF:0]           fp_valid_q;
  logic [32:0]           diff_full;
  logic [32:0]           range_full;
  logic                  below_lo;

  assign diff_full  = 33'($signed({src_word.sample[31], src_word.sample})
                      - $signed({pv_lower_q[31], pv_lower_q}));
  assign range_full = 33'($signed({pv_upper_q[31], pv_upper_q})
                      - $signed({pv_lower_q[31], pv_lower_q}));
  assign below_lo   = $signed(src_word.sample) < $signed(pv_lower_q);

  always_comb begin
    logic [32:0] shifted;
    logic        ge;
    fp_d[0].op         = src_word.op;
    fp_d[0].force_zero = below_lo;
    fp_d[0].force_one  = !below_lo && ($signed(pv_upper_q) <= $signed(pv_lower_q)
                         || $signed(src_word.sample) >= $signed(pv_upper_q));
    fp_d[0].rem        = diff_full[31:0];
    fp_d[0].range      = range_full[31:0];
    fp_d[0].quot       = '0;
    for (int k = 0; k < NF; k++) begin
      shifted    = {fp_q[k].rem, 1'b0};
      ge         = shifted >= {1'b0, fp_q[k].range};
      fp_d[k+1]  = fp_q[k];
      fp_d[k+1].rem  = ge ? 32'(shifted - {1'b0, fp_q[k].range}) : shifted[31:0];
      fp_d[k+1].quot = {fp_q[k].quot[hdcc_pkg::FracBits-2:0], ge};
    end
  end

  // ---------------------------------------------------------------------------
  // Cycle time: K * 65536 / divisor, one quotient bit per stage. The remainder
  // stays below the divisor, so 17 bits carry it.
  // ---------------------------------------------------------------------------
  hdcc_pkg::div_stage_t      dp_q [ND+1];
  hdcc_pkg::div_stage_t      dp_d [ND+1];
  logic [ND:0]               dp_valid_q;
  logic [hdcc_pkg::FracW-1:0] frac_fin;
  logic [hdcc_pkg::FracW-1:0] dvsr_fin;
  logic [hdcc_pkg::QuotW-1:0] numer;

  assign numer = {hdcc_pkg::half_cycle_secs(cph_sel_q), hdcc_pkg::FracBits'(0)};

  always_comb begin
    if (fp_q[NF].force_one) begin
      frac_fin = hdcc_pkg::FracOne;
    end else if (fp_q[NF].force_zero) begin
      frac_fin = '0;
    end else begin
      frac_fin = {1'b0, fp_q[NF].quot};
    end
    dvsr_fin = (fp_q[NF].op == hdcc_pkg::OpOnTime) ? hdcc_pkg::FracOne - frac_fin : frac_fin;
  end

  always_comb begin
    logic [hdcc_pkg::FracW:0] shifted;
    logic                     ge;
    dp_d[0].op    = fp_q[NF].op;
    dp_d[0].dzero = dvsr_fin == '0;
    dp_d[0].dvsr  = dvsr_fin;
    dp_d[0].rem   = '0;
    dp_d[0].quot  = '0;
    for (int j = 0; j < ND; j++) begin
      shifted   = {dp_q[j].rem, numer[ND-1-j]};
      ge        = shifted >= {1'b0, dp_q[j].dvsr};
      dp_d[j+1] = dp_q[j];
      dp_d[j+1].rem  = ge ? hdcc_pkg::FracW'(shifted - {1'b0, dp_q[j].dvsr})
                          : shifted[hdcc_pkg::FracW-1:0];
      dp_d[j+1].quot = {dp_q[j].quot[hdcc_pkg::QuotW-2:0], ge};
    end
  end

  // Stage registers: valid bits reset, payload does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_valid_q <= '0;
      dp_valid_q <= '0;
    end else if (pipe_en) begin
      fp_valid_q <= {fp_valid_q[NF-1:0], src_valid};
      dp_valid_q <= {dp_valid_q[ND-1:0], fp_valid_q[NF]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k <= NF; k++) begin
        fp_q[k] <= fp_d[k];
      end
      for (int j = 0; j <= ND; j++) begin
        dp_q[j] <= dp_d[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: saturate on a zero divisor, raise to the capped minimum, zero the word on an invalid option.
  // The quotient is at most 450 * 65536, so it never overflows 32 bits.
  // ---------------------------------------------------------------------------
  logic [31:0]                 cycle_raw, min_req, min_cap, cycle_fin;
  logic [hdcc_pkg::LimitW-1:0] limit;
  logic                        cph_bad;
  logic [47:0]                 out_data_q;
  logic                        out_user_q;

  assign cph_bad   = 32'(cph_sel_q) >= 32'(hdcc_pkg::NumCph);
  assign limit     = hdcc_pkg::max_min_limit(cph_sel_q);
  assign cycle_raw = dp_q[ND].dzero ? '1 : 32'(dp_q[ND].quot);
  assign min_req   = (dp_q[ND].op == hdcc_pkg::OpOnTime) ? min_on_q : min_off_q;
  assign min_cap   = (min_req > 32'(limit)) ? 32'(limit) : min_req;
  assign cycle_fin = (cycle_raw < min_cap) ? min_cap : cycle_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= dp_valid_q[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      if (cph_bad) begin
        out_data_q <= '0;
        out_user_q <= 1'b1;
      end else begin
        out_data_q <= {6'b0, limit, cycle_fin};
        out_user_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

`ifndef SYNTHESIS
  // A stall must freeze the valid bit of every divider stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(fp_valid_q) && $stable(dp_valid_q))
    else $error("pipeline valid bits moved during a stall");

  // An invalid option yields an all-zero data word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("invalid option word carries nonzero data");

  // A valid option always reports a nonzero limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[41:32] != '0)
    else $error("valid option word has a zero minimum-time limit");
`endif

endmodule

// ----- verif/hvac_cycle_time_checker.sv -----
// Watches both streams and the register port of the HVAC duty-cycle time calculator,
// predicts every result word and compares it field by field. Depends on hdcc_pkg.
`timescale 1ns / 100ps

module hvac_cycle_time_checker
  import hdcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [31:0]          s_tdata_i,    // [31:0] pv_sample
  input  logic [0:0]           s_tuser_i,    // [0] op
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [47:0]          m_tdata_i,    // [31:0] cycle_seconds, [41:32] min_time_limit
  input  logic [0:0]           m_tuser_i,    // [0] cph_invalid
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [AddrW-1:0]     paddr_i,
  input  logic [31:0]          pwdata_i,
  input  logic                 pready_i,
  output int                   error_count_o,
  output int                   pending_o
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [31:0]       cycle_seconds;
    logic [LimitW-1:0] min_time_limit;
    logic              cph_invalid;
  } cycle_time_t;

  // Shadow of the register file, updated from observed writes.
  logic signed [31:0] pv_lo;
  logic signed [31:0] pv_hi;
  logic [SelW-1:0]    cph_sel;
  logic [31:0]        min_on;
  logic [31:0]        min_off;

  cycle_time_t expected_times[$];
  int          error_count = 0;

  assign error_count_o = error_count;

  function automatic cycle_time_t predict_cycle_time(input logic op,
                                                     input logic signed [31:0] pv);
    cycle_time_t       r;
    longint            lo, hi, span, s;
    u64_t              frac, dvsr, quo, k;
    logic [31:0]       floor_req;
    logic [LimitW-1:0] lim;
    r = '0;
    case (cph_sel)
      3'd0:    begin k = 450; lim = 900; end
      3'd1:    begin k = 300; lim = 600; end
      3'd2:    begin k = 225; lim = 450; end
      3'd3:    begin k = 180; lim = 360; end
      3'd4:    begin k = 150; lim = 300; end
      default: begin k = 0;   lim = 0;   end
    endcase
    if (cph_sel >= NumCph) begin
      r.cph_invalid = 1'b1;
      return r;
    end
    lo   = longint'(pv_lo);
    hi   = longint'(pv_hi);
    s    = longint'(pv);
    span = hi - lo;
    // Load fraction in Q0.16, clamped to 0..1.0.
    if (s < lo) begin
      frac = 0;
    end else if (span <= 0) begin
      frac = 65536;
    end else begin
      frac = (u64_t'(s - lo) << 16) / u64_t'(span);
      if (frac > 65536) frac = 65536;
    end
    dvsr = (op == OpOnTime) ? 65536 - frac : frac;
    if (dvsr == 0) begin
      r.cycle_seconds = '1;
    end else begin
      quo = (k << 16) / dvsr;
      r.cycle_seconds = (quo > 64'hFFFF_FFFF) ? '1 : 32'(quo);
    end
    floor_req = (op == OpOnTime) ? min_on : min_off;
    if (floor_req > lim) floor_req = lim;
    if (r.cycle_seconds < floor_req) r.cycle_seconds = floor_req;
    r.min_time_limit = lim;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cycle_time_t want;
    if (!rst_ni) begin
      pv_lo     <= 32'sh0000_0000;
      pv_hi     <= 32'sh0001_0000;
      cph_sel   <= '0;
      min_on    <= '0;
      min_off   <= '0;
      pending_o <= 0;
      expected_times.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          RegPvLower: pv_lo   <= pwdata_i;
          RegPvUpper: pv_hi   <= pwdata_i;
          RegCphSel:  cph_sel <= pwdata_i[SelW-1:0];
          RegMinOn:   min_on  <= pwdata_i;
          RegMinOff:  min_off <= pwdata_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_times.size() == 0) begin
          report_mismatch("unexpected word", m_tdata_i[31:0], '0);
        end else begin
          want = expected_times.pop_front();
          if (m_tdata_i[31:0] !== want.cycle_seconds)
            report_mismatch("cycle_seconds", m_tdata_i[31:0], want.cycle_seconds);
          if (m_tdata_i[41:32] !== want.min_time_limit)
            report_mismatch("min_time_limit", 32'(m_tdata_i[41:32]),
                            32'(want.min_time_limit));
          if (m_tuser_i[0] !== want.cph_invalid)
            report_mismatch("cph_invalid", 32'(m_tuser_i[0]), 32'(want.cph_invalid));
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_times.push_back(predict_cycle_time(s_tuser_i[0], s_tdata_i));
      pending_o <= expected_times.size();
    end
  end

endmodule

// ----- verif/hvac_duty_cycle_time_calc_tb.sv -----
// Top of the testbench for the HVAC duty-cycle time calculator: clock, reset, stimulus
// and verdict. Depends on hdcc_pkg, the block itself and hvac_cycle_time_checker.
`timescale 1ns / 100ps

module hvac_duty_cycle_time_calc_tb;
  import hdcc_pkg::*;

  typedef longint unsigned u64_t;

  localparam longint PvMax = 64'sh7FFF_FFFF;
  localparam longint PvMin = -64'sh8000_0000;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;   // [31:0] pv_sample
  logic [0:0]         s_axis_tuser;   // [0] op
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [47:0]        m_axis_tdata;   // [31:0] cycle_seconds, [41:32] min_time_limit
  logic [0:0]         m_axis_tuser;   // [0] cph_invalid
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;

  // Random idling is switched off for the closing part of the run. The quiet flag
  // gives the sender stretches without gaps, and the hold request asks the
  // receiver for one long stall.
  bit idle_en     = 1'b1;
  bit quiet       = 1'b0;
  bit rx_hold_req = 1'b0;

  hvac_duty_cycle_time_calc dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  hvac_cycle_time_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .error_count_o (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or a result never shows up.
  initial begin : watchdog
    #400_000;
    $display("hvac_duty_cycle_time_calc_tb: errors");
    $finish;
  end

  // Receiver side. Ready is dropped in random bursts between stretches of
  // readiness. On request it holds ready low so that the pipeline and its skid
  // register fill and the input stalls.
  initial begin : result_sink
    int held;
    m_axis_tready = 1'b0;
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < 400) begin
          @(posedge clk_i);
          held++;
        end
        rx_hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (idle_en ? $urandom_range(1, 30) : 1) @(posedge clk_i);
      end
    end
  end

  // Offers one sample and returns at the edge where it is taken, or after the random gap
  // that may follow it. Valid stays high into the next word unless such a gap follows.
  task automatic send_word(input logic op, input logic [31:0] sample);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (idle_en && !quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every predicted word has come out. The first
  // edge is always waited for, so a word taken just now is counted as pending.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write: setup cycle, then access cycle until pready. Select is left
  // high so that back-to-back writes need no lowering and raising in one step.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Registers are only touched once the pipeline is empty, since the entry stage, the
  // cycle-time divider and the output stage read them live.
  task automatic set_config(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [2:0] sel, input logic [31:0] on_min,
                            input logic [31:0] off_min);
    drain_results();
    write_reg(RegPvLower, lo);
    write_reg(RegPvUpper, hi);
    write_reg(RegCphSel, {29'd0, sel});
    write_reg(RegMinOn, on_min);
    write_reg(RegMinOff, off_min);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Half of the samples fall in or just around the configured range so that the load
  // fraction covers 0..1 densely; the rest are the bounds, their neighbors, the
  // extremes of the field and fully random words.
  function automatic logic [31:0] pick_sample(input logic signed [31:0] lo,
                                              input logic signed [31:0] hi);
    longint span, off, v;
    u64_t   r;
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return lo;
      2:       return hi;
      3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4:       return $urandom_range(0, 1) ? lo - 32'd1 : hi + 32'd1;
      default: begin
        span = longint'(hi) - longint'(lo);
        if (span <= 0) span = 64'd1 << 20;
        r   = {$urandom, $urandom};
        off = longint'(r % u64_t'(span + span / 4 + 1)) - span / 8;
        v   = longint'(lo) + off;
        if (v > PvMax) v = PvMax;
        if (v < PvMin) v = PvMin;
        return 32'(v);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_min();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return $urandom_range(0, 1000);
      2:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int          phase, i;
    int unsigned width;
    logic [31:0] lo, hi;
    logic [2:0]  sel;
    logic        op;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults: range 0..1.0, option 0, no minimum times.
    // Off time at zero load and on time at full load divide by zero.
    send_word(OpOffTime, 32'h0000_0000);
    send_word(OpOnTime,  32'h0000_0000);
    send_word(OpOffTime, 32'h0001_0000);
    send_word(OpOnTime,  32'h0001_0000);
    send_word(OpOffTime, 32'h0000_8000);
    // Above the upper bound the fraction clamps to 1.0; below the lower it is 0.
    send_word(OpOnTime,  32'h7FFF_FFFF);
    send_word(OpOffTime, 32'h8000_0000);
    send_word(OpOnTime,  32'hFFFF_FFFF);
    // Smallest non-zero divisors give the largest quotients.
    send_word(OpOffTime, 32'h0000_0001);
    send_word(OpOnTime,  32'h0000_FFFF);

    // Empty range: full load at or above the lower bound, zero load below it.
    set_config(32'h0005_0000, 32'h0005_0000, 3'd1, '0, '0);
    send_word(OpOffTime, 32'h0005_0000);
    send_word(OpOnTime,  32'h0004_FFFF);

    // Out-of-range option selectors flag the result instead of computing it.
    set_config(32'h0000_0000, 32'h0001_0000, 3'd5, '0, '0);
    send_word(OpOffTime, 32'h0000_4000);
    set_config(32'h0001_0000, 32'h0000_0000, 3'd7, '1, '1);
    send_word(OpOnTime,  32'h0000_4000);

    // Minimum times: the on minimum is capped at the option limit, the off
    // minimum lies below it, and both lift short results.
    set_config(32'h0000_0000, 32'h0001_0000, 3'd4, '1, 32'd250);
    send_word(OpOnTime,  32'h0000_4000);
    send_word(OpOnTime,  32'h0000_0000);
    send_word(OpOffTime, 32'h0001_0000);
    send_word(OpOffTime, 32'h0000_4000);

    // Widest possible range, spanning the whole sample field.
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 3'd2, '0, '1);
    send_word(OpOffTime, 32'h8000_0000);
    send_word(OpOnTime,  32'h7FFF_FFFF);
    send_word(OpOffTime, 32'h0000_0000);
    send_word(OpOffTime, 32'h7FFF_FFFF);

    // Random phases, each with its own register setting. One phase runs into a
    // long receiver hold-off, one pauses midway until all results are out, and
    // the last two run without any idling.
    for (phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 5))
        0: begin
          lo = $urandom;
          hi = $urandom;
        end
        4: begin
          lo = $urandom;
          hi = lo;
        end
        5: begin
          lo = 32'h8000_0000;
          hi = 32'h7FFF_FFFF;
          if ($urandom_range(0, 1)) {lo, hi} = {hi, lo};
        end
        default: begin
          // A plausible temperature band: lower end from -200 to under 201 degrees and a
          // width anywhere from one LSB to 128 degrees.
          width = 32'd1 << $urandom_range(0, 22);
          lo = ($urandom_range(0, 400) << 16) - (32'd200 << 16) + $urandom_range(0, 65535);
          hi = lo + width + $urandom_range(0, width);
        end
      endcase
      sel = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      set_config(lo, hi, sel, pick_min(), pick_min());

      idle_en = (phase < 10);
      if (phase == 3) begin
        rx_hold_req = 1'b1;
        quiet       = 1'b1;
      end
      for (i = 0; i < 130; i++) begin
        if (phase != 3 && i % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (phase == 6 && i == 65) drain_results();
        op = $urandom_range(0, 1) ? OpOnTime : OpOffTime;
        send_word(op, pick_sample(lo, hi));
      end
    end

    // Everything offered: wait for the last results, then a little longer than
    // the pipeline latency to catch any stray word.
    drain_results();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("hvac_duty_cycle_time_calc_tb: clean");
    end else begin
      $display("hvac_duty_cycle_time_calc_tb: errors");
    end
    $finish;
  end

endmodule
